// File: sv/mrpid_pkg.sv
package mrpid_pkg;

    // Default sizing
    localparam int DUTY_MAX_DEF  = 255;
    localparam int SUM_WIDTH_DEF = 24;

    // Speed scaling: counts per ms to rpm
    localparam int SPEED_SCALE = 60000;

    // Field widths
    localparam int GAIN_W     = 16;
    localparam int CNT_W      = 32;
    localparam int SPD_W      = 16;
    localparam int ERR_W      = 17;
    localparam int LAST_ERR_W = 18;
    localparam int MULB_W     = 17;
    localparam int NUM_W      = 48;
    localparam int QUOT_W     = 17;
    localparam int FRAC_BITS  = 8;
    localparam int FRAC_MASK  = (1 << FRAC_BITS) - 1;

    // Register reset values
    localparam logic [GAIN_W-1:0] KP_RESET  = 16'd256;
    localparam logic [GAIN_W-1:0] KI_RESET  = 16'd0;
    localparam logic [GAIN_W-1:0] KD_RESET  = 16'd0;
    localparam logic [GAIN_W-1:0] TPR_RESET = 16'd1024;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 2'd0,
        CFG_INTEG_GAIN    = 2'd1,
        CFG_DERIV_GAIN    = 2'd2,
        CFG_TICKS_PER_REV = 2'd3
    } t_cfg_idx;

endpackage

// File: sv/motor_rpm_pid_pwm_unit.sv
// Motor speed PID controller with two-channel PWM drive. Each accepted
// transaction carries an encoder count, a millisecond time stamp, a target
// speed and a stop flag, and yields one result: measured speed in rpm
// (delta*60000/(ticks_per_rev*dt), truncated and saturated, held when the
// time stamp has not moved), the clamped signed duty and the two one-sided
// drive levels. A stop request clears the integral and derivative history
// and forces all drive outputs to zero. All arithmetic goes through one
// shared signed multiplier and a bit-serial restoring divider under a small
// sequencer; the input side stalls until the current transaction is done.
// A recomputed speed passes the multiplier steps, the divider and the PID
// steps; an unchanged time stamp skips the multiplier and divider steps, a
// stop skips the PID multiplies, and a quotient known to saturate before
// dividing skips the divider steps. A finished result waits in the output
// register, so the next transaction is accepted while it is held. Gains and
// ticks_per_rev may be written whenever the block is idle.
module motor_rpm_pid_pwm_unit
    import mrpid_pkg::*;
#(
    parameter int DUTY_MAX  = DUTY_MAX_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [GAIN_W-1:0]           i_cfg_data,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [CNT_W-1:0]     i_encoder_count,
    input  logic [CNT_W-1:0]            i_time_ms,
    input  logic signed [SPD_W-1:0]     i_target_rpm,
    input  logic                        i_stop_req,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [8:0]           o_duty,
    output logic [7:0]                  o_drive_a,
    output logic [7:0]                  o_drive_b,
    output logic signed [SPD_W-1:0]     o_speed_rpm
);

    // Derived widths
    localparam int AW     = (SUM_WIDTH > CNT_W + 1) ? SUM_WIDTH : CNT_W + 1;
    localparam int PW     = AW + MULB_W;
    localparam int ACC_W  = PW + 2;
    localparam int QW     = ACC_W - FRAC_BITS;
    localparam int DW     = $clog2(DUTY_MAX + 1) + 1;
    localparam int CW     = (DW > 10) ? DW : 10;
    localparam int DCNT_W = $clog2(QUOT_W);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(QUOT_W - 1);
    localparam logic signed [QW-1:0] DMAX_POS = QW'(DUTY_MAX);
    localparam logic signed [QW-1:0] DMAX_NEG = -QW'(DUTY_MAX);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_N, S_MUL_D, S_DIV_CHK, S_DIV, S_SPD, S_ERR,
        S_MP, S_MI, S_MD, S_ACC, S_RND, S_FIN
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [GAIN_W-1:0] r_kp, r_ki, r_kd, r_tpr;

    // Controller state
    logic [CNT_W-1:0]                r_last_count, r_last_time;
    logic signed [SPD_W-1:0]         r_speed;
    logic signed [SUM_WIDTH-1:0]     r_sum;
    logic signed [LAST_ERR_W-1:0]    r_last_err;

    // Per-transaction working registers
    logic [CNT_W-1:0]                r_mag, r_dt;
    logic                            r_neg, r_stop, r_ovf;
    logic signed [SPD_W-1:0]         r_target;
    logic signed [PW-1:0]            r_prod;
    logic [NUM_W-1:0]                r_num;
    logic [NUM_W+QUOT_W-2:0]         r_ds;
    logic [QUOT_W-1:0]               r_q;
    logic [DCNT_W-1:0]               r_cnt;
    logic signed [ERR_W-1:0]         r_err;
    logic signed [ACC_W-1:0]         r_acc;

    // Output register
    logic                            r_ovalid;
    logic signed [8:0]               r_duty;
    logic [7:0]                      r_drv_a, r_drv_b;
    logic signed [SPD_W-1:0]         r_ospeed;

    // Combinational helpers
    logic                            in_acc, out_free;
    logic [CNT_W-1:0]                delta, dt;
    logic [GAIN_W-1:0]               tpr_eff;
    logic signed [AW-1:0]            mul_a;
    logic signed [MULB_W-1:0]        mul_b;
    logic signed [PW-1:0]            mul_p;
    logic                            div_ovf, div_ge;
    logic signed [SPD_W-1:0]         n_speed;
    logic signed [ERR_W-1:0]         n_err;
    logic signed [SUM_WIDTH:0]       sum_raw;
    logic signed [SUM_WIDTH-1:0]     n_sum;
    logic signed [LAST_ERR_W:0]      derr;
    logic signed [QW-1:0]            acc_q, acc_cl;
    logic signed [CW-1:0]            duty_c, duty_mag;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    assign delta   = i_encoder_count - r_last_count;
    assign dt      = i_time_ms - r_last_time;
    assign tpr_eff = (r_tpr == '0) ? GAIN_W'(1) : r_tpr;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_N: begin
                mul_a = AW'(r_mag);
                mul_b = MULB_W'(SPEED_SCALE);
            end
            S_MUL_D: begin
                mul_a = AW'(r_dt);
                mul_b = {1'b0, tpr_eff};
            end
            S_MP: begin
                mul_a = AW'(r_err);
                mul_b = {r_kp[GAIN_W-1], r_kp};
            end
            S_MI: begin
                mul_a = AW'(r_sum);
                mul_b = {r_ki[GAIN_W-1], r_ki};
            end
            S_MD: begin
                mul_a = AW'(derr);
                mul_b = {r_kd[GAIN_W-1], r_kd};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divider compares
    assign div_ovf = {{(QUOT_W){1'b0}}, r_num} >= {r_prod[NUM_W-1:0], {(QUOT_W){1'b0}}};
    assign div_ge  = {{(QUOT_W-1){1'b0}}, r_num} >= r_ds;

    // Speed from quotient with saturation
    always_comb begin
        if (r_neg) begin
            if (r_ovf || r_q > QUOT_W'(32768)) begin
                n_speed = {1'b1, {(SPD_W-1){1'b0}}};
            end else begin
                n_speed = SPD_W'(-r_q);
            end
        end else begin
            if (r_ovf || r_q > QUOT_W'(32767)) begin
                n_speed = {1'b0, {(SPD_W-1){1'b1}}};
            end else begin
                n_speed = r_q[SPD_W-1:0];
            end
        end
    end

    // Error and saturating integral
    assign n_err   = ERR_W'(r_target) - ERR_W'(r_speed);
    assign sum_raw = (SUM_WIDTH+1)'(r_sum) + (SUM_WIDTH+1)'(n_err);
    always_comb begin
        if (sum_raw[SUM_WIDTH] != sum_raw[SUM_WIDTH-1]) begin
            n_sum = sum_raw[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            n_sum = sum_raw[SUM_WIDTH-1:0];
        end
    end
    assign derr = (LAST_ERR_W+1)'(r_err) - (LAST_ERR_W+1)'(r_last_err);

    // Scale down and clamp the duty
    assign acc_q = $signed(r_acc[ACC_W-1:FRAC_BITS]);
    always_comb begin
        if (acc_q > DMAX_POS) begin
            acc_cl = DMAX_POS;
        end else if (acc_q < DMAX_NEG) begin
            acc_cl = DMAX_NEG;
        end else begin
            acc_cl = acc_q;
        end
    end
    assign duty_c   = acc_cl[CW-1:0];
    assign duty_mag = duty_c[CW-1] ? -duty_c : duty_c;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= KP_RESET;
            r_ki  <= KI_RESET;
            r_kd  <= KD_RESET;
            r_tpr <= TPR_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PROP_GAIN:     r_kp  <= i_cfg_data;
                CFG_INTEG_GAIN:    r_ki  <= i_cfg_data;
                CFG_DERIV_GAIN:    r_kd  <= i_cfg_data;
                CFG_TICKS_PER_REV: r_tpr <= i_cfg_data;
            endcase
        end
    end

    // Sequencer, controller state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_last_count <= '0;
            r_last_time  <= '0;
            r_speed      <= '0;
            r_sum        <= '0;
            r_last_err   <= '0;
        end else begin
            // result taken; a new one loaded in S_FIN keeps it set
            if (r_ovalid && !i_stall && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last_count <= i_encoder_count;
                        r_last_time  <= i_time_ms;
                        r_state      <= (dt == '0) ? S_SPD : S_MUL_N;
                    end
                end
                S_MUL_N:   r_state <= S_MUL_D;
                S_MUL_D:   r_state <= S_DIV_CHK;
                S_DIV_CHK: r_state <= div_ovf ? S_SPD : S_DIV;
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_SPD;
                    end
                end
                S_SPD: begin
                    if (r_dt != '0) begin
                        r_speed <= n_speed;
                    end
                    if (r_stop) begin
                        r_sum      <= '0;
                        r_last_err <= '0;
                        r_state    <= S_RND;
                    end else begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_sum   <= n_sum;
                    r_state <= S_MP;
                end
                S_MP:  r_state <= S_MI;
                S_MI:  r_state <= S_MD;
                S_MD: begin
                    r_last_err <= LAST_ERR_W'(r_err);
                    r_state    <= S_ACC;
                end
                S_ACC: r_state <= S_RND;
                S_RND: r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_duty   <= duty_c[8:0];
                        r_drv_a  <= duty_c[CW-1] ? duty_mag[7:0] : 8'd0;
                        r_drv_b  <= (!duty_c[CW-1] && duty_c != '0) ? duty_mag[7:0] : 8'd0;
                        r_ospeed <= r_speed;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state) inside
            S_IDLE: begin
                r_neg    <= delta[CNT_W-1];
                r_mag    <= delta[CNT_W-1] ? -delta : delta;
                r_dt     <= dt;
                r_target <= i_target_rpm;
                r_stop   <= i_stop_req;
                r_ovf    <= 1'b0;
            end
            S_MUL_D: begin
                r_num <= r_prod[NUM_W-1:0];
            end
            S_DIV_CHK: begin
                r_ovf <= div_ovf;
                r_ds  <= {r_prod[NUM_W-1:0], {(QUOT_W-1){1'b0}}};
                r_q   <= '0;
                r_cnt <= DIV_LAST;
            end
            S_DIV: begin
                if (div_ge) begin
                    r_num <= r_num - r_ds[NUM_W-1:0];
                end
                r_q   <= {r_q[QUOT_W-2:0], div_ge};
                r_ds  <= r_ds >> 1;
                r_cnt <= r_cnt - DCNT_W'(1);
            end
            S_SPD: begin
                r_acc <= '0;
            end
            S_ERR: begin
                r_err <= n_err;
            end
            S_MI: begin
                r_acc <= ACC_W'(r_prod);
            end
            S_MD, S_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            S_RND: begin
                if (r_acc[ACC_W-1]) begin
                    r_acc <= r_acc + ACC_W'(FRAC_MASK);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_duty      = r_duty;
    assign o_drive_a   = r_drv_a;
    assign o_drive_b   = r_drv_b;
    assign o_speed_rpm = r_ospeed;

    // Checks
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_drive_a != 8'd0 && o_drive_b != 8'd0))
        else $error("both drive channels active");

    a_side_by_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty[8] ? (o_drive_b == 8'd0) : (o_drive_a == 8'd0)))
        else $error("drive channel does not match duty sign");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again before transaction finished");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divider step count out of range");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mrpid_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 60;

    // one result transaction as seen on the output channel
    typedef struct {
        logic signed [8:0]  duty;
        logic [7:0]         drive_a;
        logic [7:0]         drive_b;
        logic signed [15:0] speed;
    } t_drive_result;

    // Scoreboard: predicts the speed and PID duty for each accepted input
    // transaction and checks results in order.
    class speed_pid_scoreboard;
        logic signed [15:0] kp, ki, kd;
        logic [15:0]        tpr;
        logic [31:0]        prev_count, prev_time;
        logic signed [15:0] speed;
        longint             err_sum, prev_err;
        t_drive_result      expected_q[$];
        int errors, n_txn, n_stop, n_held, n_sat, n_checked, n_settings;

        function new();
            kp = KP_RESET;
            ki = KI_RESET;
            kd = KD_RESET;
            tpr = TPR_RESET;
            prev_count = '0;
            prev_time = '0;
            speed = '0;
            err_sum = 0;
            prev_err = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            else if (errors == MAX_REPORTS + 1)
                $display("[%0t] further mismatches counted but not printed", $realtime);
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] val);
            case (idx)
                CFG_PROP_GAIN:     kp = val;
                CFG_INTEG_GAIN:    ki = val;
                CFG_DERIV_GAIN:    kd = val;
                CFG_TICKS_PER_REV: tpr = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // speed measurement and PID step for one input transaction
        function void note_input(logic [31:0] cnt, logic [31:0] tm,
                                 logic signed [15:0] tgt, logic stp);
            logic [31:0]       delta_u, dt;
            longint            delta, err, acc, d, smax;
            longint unsigned   mag, divisor, q;
            t_drive_result     r;
            n_txn++;
            delta_u = cnt - prev_count;
            delta = longint'($signed(delta_u));
            dt = tm - prev_time;
            if (dt != 0) begin
                divisor = longint'((tpr == 0) ? 16'd1 : tpr) * longint'(dt);
                mag = (delta < 0) ? -delta : delta;
                q = (mag * SPEED_SCALE) / divisor;
                if (delta < 0) begin
                    if (q > 32768) n_sat++;
                    speed = (q > 32768) ? 16'sh8000 : 16'(-longint'(q));
                end else begin
                    if (q > 32767) n_sat++;
                    speed = (q > 32767) ? 16'sh7fff : 16'(q);
                end
            end else begin
                n_held++;
            end
            prev_count = cnt;
            prev_time = tm;

            d = 0;
            if (stp) begin
                n_stop++;
                err_sum = 0;
                prev_err = 0;
            end else begin
                smax = (longint'(1) << (SUM_WIDTH_DEF - 1)) - 1;
                err = longint'(tgt) - longint'(speed);
                err_sum = err_sum + err;
                if (err_sum > smax) err_sum = smax;
                if (err_sum < -smax - 1) err_sum = -smax - 1;
                acc = longint'(kp) * err + longint'(ki) * err_sum
                    + longint'(kd) * (err - prev_err);
                d = acc / 256;
                if (d > DUTY_MAX_DEF) d = DUTY_MAX_DEF;
                if (d < -DUTY_MAX_DEF) d = -DUTY_MAX_DEF;
                prev_err = err;
            end

            r.duty = 9'(d);
            r.drive_a = (d < 0) ? 8'(-d) : 8'd0;
            r.drive_b = (d > 0) ? 8'(d) : 8'd0;
            r.speed = speed;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_drive_result got);
            t_drive_result want;
            n_checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing pending: duty %0d speed %0d",
                                 got.duty, got.speed));
                return;
            end
            want = expected_q.pop_front();
            if (got.duty !== want.duty)
                report($sformatf("result %0d duty %0d, want %0d",
                                 n_checked, got.duty, want.duty));
            if (got.drive_a !== want.drive_a)
                report($sformatf("result %0d drive_a %0d, want %0d",
                                 n_checked, got.drive_a, want.drive_a));
            if (got.drive_b !== want.drive_b)
                report($sformatf("result %0d drive_b %0d, want %0d",
                                 n_checked, got.drive_b, want.drive_b));
            if (got.speed !== want.speed)
                report($sformatf("result %0d speed %0d, want %0d",
                                 n_checked, got.speed, want.speed));
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    t_cfg_idx               i_cfg_idx;
    logic [GAIN_W-1:0]      i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [31:0]     i_encoder_count;
    logic [31:0]            i_time_ms;
    logic signed [15:0]     i_target_rpm;
    logic                   i_stop_req;
    logic                   o_valid;
    logic                   i_stall;
    logic signed [8:0]      o_duty;
    logic [7:0]             o_drive_a;
    logic [7:0]             o_drive_b;
    logic signed [15:0]     o_speed_rpm;

    speed_pid_scoreboard    sb;
    logic [31:0]            cur_count;
    logic [31:0]            cur_time;
    logic                   quiet;
    logic                   hold_req;
    int                     cycles;

    motor_rpm_pid_pwm_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_encoder_count (i_encoder_count),
        .i_time_ms       (i_time_ms),
        .i_target_rpm    (i_target_rpm),
        .i_stop_req      (i_stop_req),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_duty          (o_duty),
        .o_drive_a       (o_drive_a),
        .o_drive_b       (o_drive_b),
        .o_speed_rpm     (o_speed_rpm)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: short and long stalls, or one long hold-off on request
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
                if (!quiet) begin
                    r = $urandom_range(0, 99);
                    if (r < 12) stall_left = $urandom_range(1, 3);
                    else if (r < 14) stall_left = $urandom_range(15, 60);
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_drive_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.duty = o_duty;
            got.drive_a = o_drive_a;
            got.drive_b = o_drive_b;
            got.speed = o_speed_rpm;
            sb.check_result(got);
        end
    end

    // one input transaction, then a random gap
    task automatic send_txn(logic [31:0] cnt, logic [31:0] tm,
                            logic [15:0] tgt, logic stp);
        int r;
        int gap;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_encoder_count = cnt;
        i_time_ms = tm;
        i_target_rpm = tgt;
        i_stop_req = stp;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(cnt, tm, tgt, stp);
        cur_count = cnt;
        cur_time = tm;
        gap = 0;
        if (!quiet) begin
            r = $urandom_range(0, 99);
            if (r >= 92) gap = $urandom_range(10, 60);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // every transaction yields a result, so an empty queue means idle
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                             logic [15:0] tpr);
        drain();
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_TICKS_PER_REV, tpr);
        sb.n_settings++;
    endtask

    // plausible motion with random steps, plus some unrelated noise
    task automatic run_motion(int n, int max_step, int tgt_span, int stop_pct,
                              int noise_pct);
        int k;
        int r;
        int dt;
        int delta;
        int tgt;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < noise_pct) begin
                send_txn($urandom, $urandom, 16'($urandom), 1'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) dt = 0;
                else if (r < 13) dt = $urandom;
                else dt = $urandom_range(1, 20);
                r = $urandom_range(0, 99);
                if (r < 3) delta = $urandom;
                else delta = int'($urandom_range(0, 2 * max_step)) - max_step;
                tgt = int'($urandom_range(0, 2 * tgt_span)) - tgt_span;
                send_txn(cur_count + delta, cur_time + dt, 16'(tgt),
                         $urandom_range(0, 99) < stop_pct);
            end
        end
    endtask

    // target far from a saturated speed, to drive the integral toward its limit
    task automatic run_windup(int n, int dir);
        int k;
        int delta;
        int tgt;
        for (k = 0; k < n; k++) begin
            delta = -dir * int'($urandom_range(600, 3000));
            tgt = dir * int'($urandom_range(32000, 32767));
            send_txn(cur_count + delta, cur_time + 1, 16'(tgt), 1'b0);
        end
    endtask

    initial begin
        sb = new();
        quiet = 1'b0;
        hold_req = 1'b0;
        cur_count = '0;
        cur_time = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_PROP_GAIN;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_encoder_count = '0;
        i_time_ms = '0;
        i_target_rpm = '0;
        i_stop_req = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset register values
        send_txn(32'd0, 32'd0, 16'sd0, 1'b0);                   // no elapsed time
        send_txn(32'd1024, 32'd1, 16'sh7fff, 1'b0);             // speed saturates high
        send_txn(32'd0, 32'd2, 16'sh7fff, 1'b0);                // saturates low, duty max
        send_txn(32'h8000_0000, 32'd3, 16'sh8000, 1'b0);        // most negative count
        send_txn(32'h7fff_ffff, 32'd4, 16'sh8000, 1'b0);        // count wraps, duty min
        send_txn(32'h7fff_ffff, 32'd4, 16'sd100, 1'b0);         // speed held
        send_txn(32'h7fff_ffff, 32'd5, -16'sd100, 1'b0);        // zero speed, drive a
        send_txn(32'h8000_0000, 32'd6, 16'sd58, 1'b0);          // wrap upward
        send_txn(32'h8000_0010, 32'hffff_ffff, 16'sd0, 1'b0);   // huge elapsed time
        send_txn(32'h8000_0074, 32'd0, 16'sd0, 1'b0);           // time stamp wraps
        send_txn(32'h8000_013c, 32'd3, 16'sh7fff, 1'b1);        // stop
        send_txn(32'h8000_013c, 32'd3, 16'sh8000, 1'b1);        // stop, time unchanged
        send_txn(32'h8000_0200, 32'd13, 16'sd0, 1'b0);
        send_txn(32'hffff_fffb, 32'd20, -16'sd1, 1'b0);

        // moderate gains, with a long receiver hold-off in the middle
        set_gains(16'd100, 16'd3, 16'd50, 16'd1024);
        run_motion(60, 300, 3000, 5, 8);
        hold_req = 1'b1;
        run_motion(60, 300, 3000, 5, 8);

        // extreme gains, back to back with no idling
        quiet = 1'b1;
        set_gains(16'h8000, 16'h7fff, 16'h8000, 16'd1);
        run_motion(80, 50, 32767, 5, 10);
        quiet = 1'b0;

        set_gains(16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
        run_motion(80, 30000, 32767, 5, 10);

        // ticks_per_rev of zero acts as one
        set_gains(-16'sd40, 16'd0, 16'd700, 16'd0);
        run_motion(50, 2, 200, 5, 10);

        // integral only: wind up to the positive limit, then toward the negative one
        set_gains(16'd0, 16'd1, 16'd0, 16'd1024);
        run_windup(150, 1);
        run_windup(150, -1);
        run_motion(20, 300, 3000, 10, 5);

        // speed scale where the negative limit is hit exactly
        set_gains(16'd256, 16'd0, 16'd0, 16'd1875);
        run_motion(40, 1100, 3000, 5, 5);

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("Covered %0d transactions: %0d stops, %0d held stamps, %0d saturated speeds,",
                 sb.n_txn, sb.n_stop, sb.n_held, sb.n_sat);
        $display("over %0d register settings; %0d results checked, %0d mismatches.",
                 sb.n_settings + 1, sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: motor_rpm_pid_pwm_unit.f
sv/mrpid_pkg.sv
sv/motor_rpm_pid_pwm_unit.sv
tb/sv/tb_top.sv
